// File: rtl/core/idq_pkg.sv
package idq_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 16;

    // field widths fixed by the command format
    localparam int KEY_W = 32;
    localparam int VAL_W = 16;

    // command codes
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_FIND   = 2'd3
    } t_opcode;

    // result codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CREATED  = 3'd1,
        ST_NOLIST   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_state;

    // command beat
    typedef struct packed {
        t_opcode                   opcode;
        logic signed [VAL_W-1:0]   item_value;
        logic        [KEY_W-1:0]   search_key;
    } t_cmd;

    // result beat
    typedef struct packed {
        t_status                   status;
        logic        [KEY_W-1:0]   found_key;
        logic signed [VAL_W-1:0]   found_value;
    } t_result;

    // search token travelling down the cell chain
    typedef struct packed {
        logic                      valid;
        logic        [KEY_W-1:0]   key;
        logic                      hit;
        logic        [KEY_W-1:0]   hit_key;
        logic signed [VAL_W-1:0]   hit_value;
    } t_probe;

    // storage control broadcast to every cell
    typedef struct packed {
        logic                      shift;
        logic                      write;
        logic        [KEY_W-1:0]   key;
        logic signed [VAL_W-1:0]   value;
    } t_cell_ctl;

endpackage

// File: rtl/core/idq_cell.sv
module idq_cell #(
    parameter  int DEPTH = 16,
    parameter  int IDX   = 0,
    localparam int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  idq_pkg::t_cell_ctl                      i_ctl,
    input  logic [OCC_W-1:0]                        i_occupancy,
    input  logic [idq_pkg::KEY_W-1:0]               i_nb_key,
    input  logic signed [idq_pkg::VAL_W-1:0]        i_nb_value,
    output logic [idq_pkg::KEY_W-1:0]               o_key,
    output logic signed [idq_pkg::VAL_W-1:0]        o_value,
    input  idq_pkg::t_probe                         i_probe,
    output idq_pkg::t_probe                         o_probe
);
    import idq_pkg::*;

    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    occupied;
    t_probe                  n_probe;
    t_probe                  r_probe;

    // this cell holds a live entry when its position is below the fill count
    assign occupied = (OCC_W'(IDX) < i_occupancy);

    // entry storage: pop moves everything one cell towards the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end else if (i_ctl.write && (i_occupancy == OCC_W'(IDX))) begin
            r_key   <= i_ctl.key;
            r_value <= i_ctl.value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;

    // first match nearest the head wins, later cells leave it alone
    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.hit && occupied && (r_key == i_probe.key)) begin
            n_probe.hit       = 1'b1;
            n_probe.hit_key   = r_key;
            n_probe.hit_value = r_value;
        end
    end

    // token stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: rtl/core/idq_ctrl.sv
module idq_ctrl #(
    parameter  int DEPTH = 16,
    localparam int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  idq_pkg::t_cmd        i_cmd,
    output idq_pkg::t_cell_ctl   o_ctl,
    output logic [OCC_W-1:0]     o_occupancy,
    output idq_pkg::t_probe      o_probe,
    input  idq_pkg::t_probe      i_probe,
    output logic                 o_strobe,
    output idq_pkg::t_result     o_result
);
    import idq_pkg::*;

    t_state           r_state,    n_state;
    logic [OCC_W-1:0] r_occ,      n_occ;
    logic             r_created,  n_created;
    logic [KEY_W-1:0] r_next_key, n_next_key;
    logic             r_strobe,   n_strobe;
    t_result          r_result,   n_result;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_created  <= 1'b0;
            r_next_key <= KEY_W'(1);
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_occ      <= n_occ;
            r_created  <= n_created;
            r_next_key <= n_next_key;
            r_strobe   <= n_strobe;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // command decode and next state
    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_created  = r_created;
        n_next_key = r_next_key;
        n_strobe   = 1'b0;
        n_result   = r_result;

        o_ctl.shift = 1'b0;
        o_ctl.write = 1'b0;
        o_ctl.key   = r_next_key;
        o_ctl.value = i_cmd.item_value;

        o_probe.valid     = 1'b0;
        o_probe.key       = i_cmd.search_key;
        o_probe.hit       = 1'b0;
        o_probe.hit_key   = '0;
        o_probe.hit_value = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_strobe             = 1'b1;
                    n_result.status      = ST_OK;
                    n_result.found_key   = '0;
                    n_result.found_value = '0;
                    unique case (i_cmd.opcode)
                        OP_CREATE: begin
                            if (r_created) begin
                                n_result.status = ST_CREATED;
                            end else begin
                                // fill count is zero here, so slot 0 is written
                                n_created   = 1'b1;
                                o_ctl.write = 1'b1;
                                n_occ       = OCC_W'(1);
                                n_next_key  = r_next_key + KEY_W'(1);
                            end
                        end
                        OP_APPEND: begin
                            if (!r_created) begin
                                n_result.status = ST_NOLIST;
                            end else if (r_occ == OCC_W'(DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                o_ctl.write = 1'b1;
                                n_occ       = r_occ + OCC_W'(1);
                                n_next_key  = r_next_key + KEY_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (!r_created) begin
                                n_result.status = ST_NOLIST;
                            end else if (r_occ == '0) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                o_ctl.shift = 1'b1;
                                n_occ       = r_occ - OCC_W'(1);
                            end
                        end
                        OP_FIND: begin
                            if (!r_created) begin
                                n_result.status = ST_NOLIST;
                            end else begin
                                // launch a token into the head cell
                                n_strobe      = 1'b0;
                                o_probe.valid = 1'b1;
                                n_state       = S_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                // token leaves the tail cell with the verdict
                if (i_probe.valid) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (i_probe.hit) begin
                        n_result.status      = ST_OK;
                        n_result.found_key   = i_probe.hit_key;
                        n_result.found_value = i_probe.hit_value;
                    end else begin
                        n_result.status      = ST_NOTFOUND;
                        n_result.found_key   = '0;
                        n_result.found_value = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state == S_SEARCH);
    assign o_occupancy = r_occ;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

endmodule

// File: rtl/core/id_tagged_fifo_with_search_top.sv
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------
// command   | start / busy           | i_cmd    (opcode, item_value, search_key)
// result    | o_strobe               | o_result (status, found_key, found_value)
//
// create, append and delete: the result beat appears in the cycle after the
// command is taken and busy stays low.
// find sends a token down the chain of DEPTH cells, one cell per cycle: busy
// is high while the token travels, and the result beat is registered once the
// token leaves the tail cell.
// reset is synchronous and active low; the queue comes up not created, id 1.
// the result beat lasts one cycle and cannot be held off by the receiver.
module id_tagged_fifo_with_search_top #(
    parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  idq_pkg::t_cmd       i_cmd,
    output logic                o_strobe,
    output idq_pkg::t_result    o_result
);
    import idq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    t_cell_ctl               w_ctl;
    logic [OCC_W-1:0]        w_occ;
    t_probe                  w_probe [DEPTH+1];
    logic [KEY_W-1:0]        w_key   [DEPTH];
    logic signed [VAL_W-1:0] w_value [DEPTH];

    // controller
    idq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .o_ctl       (w_ctl),
        .o_occupancy (w_occ),
        .o_probe     (w_probe[0]),
        .i_probe     (w_probe[DEPTH]),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // chain of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0]        nb_key;
        logic signed [VAL_W-1:0] nb_value;

        // tail cell keeps its own contents on a pop
        if (g == DEPTH - 1) begin : g_tail
            assign nb_key   = w_key[g];
            assign nb_value = w_value[g];
        end else begin : g_mid
            assign nb_key   = w_key[g+1];
            assign nb_value = w_value[g+1];
        end

        idq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_occupancy (w_occ),
            .i_nb_key    (nb_key),
            .i_nb_value  (nb_value),
            .o_key       (w_key[g]),
            .o_value     (w_value[g]),
            .i_probe     (w_probe[g]),
            .o_probe     (w_probe[g+1])
        );
    end

endmodule
